@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ src/i2cbb_pkg.sv @@
// Types and constants shared by the I2C bit-bang master files.
package i2cbb_pkg;

	// Command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// Transaction modes
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_WR_RD   = 2'd2;
	localparam logic [1:0] MODE_INVALID = 2'd3;

	// Completion status codes
	localparam logic [1:0] STAT_WR_OK = 2'd0;
	localparam logic [1:0] STAT_RD_OK = 2'd1;
	localparam logic [1:0] STAT_NACK  = 2'd2;

	// Configuration register indexes
	localparam logic REG_STEP_DELAY = 1'b0;
	localparam logic REG_ACK_DELAY  = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] STEP_DELAY_RST = 8'd1;
	localparam logic [7:0] ACK_DELAY_RST  = 8'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic       sda_in;
		logic [7:0] bus_addr;
		logic [4:0] write_len;
		logic [4:0] read_len;
		logic [1:0] mode;
		logic [3:0] load_index;
		logic [7:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       rx_valid;
		logic [3:0] rx_index;
		logic [7:0] rx_byte;
		logic       done_res;
		logic [1:0] status;
		logic       busy_res;
	} out_item_t;

	typedef struct packed {
		logic [7:0] step_delay;
		logic [7:0] ack_delay;
	} cfg_t;

endpackage

@@ src/i2cbb_if.sv @@
// Valid/ready channel interfaces for input and result items.
interface i2cbb_in_if;
	logic                 valid;
	logic                 ready;
	i2cbb_pkg::in_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface i2cbb_out_if;
	logic                 valid;
	logic                 ready;
	i2cbb_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/i2cbb_core.sv @@
// Bus phase sequencer, transmit buffer and result formation for one item.
module i2cbb_core #(
	parameter int BUF_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  i2cbb_pkg::in_item_t  item,
	input  i2cbb_pkg::cfg_t      cfg,
	output i2cbb_pkg::out_item_t res
);

	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int LD_W  = (IDX_W > 4) ? IDX_W : 4;
	localparam int RD_W  = (IDX_W > 6) ? IDX_W : 6;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_TX, PH_GET_ACK, PH_RX,
		PH_SET_ACK, PH_SET_NACK, PH_STOP, PH_RESTART, PH_DELAY
	} phase_t;

	phase_t      phase_q, phase_n, ret_q, ret_n;
	logic [1:0]  sub_q, sub_n;
	logic [7:0]  dly_q, dly_n;
	logic [7:0]  txsh_q, txsh_n;
	logic [7:0]  rxsh_q, rxsh_n;
	logic [3:0]  bitc_q, bitc_n;
	logic [5:0]  txc_q, txc_n;
	logic [4:0]  rxc_q, rxc_n;
	logic [4:0]  alen_q, alen_n;
	logic [4:0]  plen_q, plen_n;
	logic        rxm_q, rxm_n;
	logic        rep_q, rep_n;
	logic        fail_q, fail_n;
	logic [7:0]  addr_q, addr_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        drv_q, drv_n;

	logic [7:0]  txbuf_q [BUF_DEPTH];
	logic [LD_W-1:0] ld_ext;
	logic [RD_W-1:0] rd_ext;
	logic        ld_ok;
	logic [7:0]  tx_byte;
	logic [7:0]  rxsh_shift;
	logic [3:0]  bitc_inc;
	logic [4:0]  rxc_inc;
	logic [5:0]  txc_inc;

	// Buffer addressing
	assign ld_ext  = LD_W'(item.load_index);
	assign rd_ext  = RD_W'(txc_q);
	assign ld_ok   = (32'(item.load_index) < BUF_DEPTH);
	assign tx_byte = (32'(txc_q) < BUF_DEPTH) ? txbuf_q[rd_ext[IDX_W-1:0]] : 8'h00;

	assign rxsh_shift = {rxsh_q[6:0], item.sda_in};
	assign bitc_inc   = bitc_q + 4'd1;
	assign rxc_inc    = rxc_q + 5'd1;
	assign txc_inc    = txc_q + 6'd1;

	// Write the transmit buffer on a load item
	always_ff @(posedge clk) begin
		if (fire && item.cmd == i2cbb_pkg::CMD_LOAD && ld_ok) begin
			txbuf_q[ld_ext[IDX_W-1:0]] <= item.load_data;
		end
	end

	// Next state and result for the current item
	always_comb begin
		phase_n = phase_q;  ret_n  = ret_q;   sub_n  = sub_q;   dly_n  = dly_q;
		txsh_n  = txsh_q;   rxsh_n = rxsh_q;  bitc_n = bitc_q;  txc_n  = txc_q;
		rxc_n   = rxc_q;    alen_n = alen_q;  plen_n = plen_q;  rxm_n  = rxm_q;
		rep_n   = rep_q;    fail_n = fail_q;  addr_n = addr_q;
		scl_n   = scl_q;    sda_n  = sda_q;   drv_n  = drv_q;
		res = '0;

		unique case (item.cmd)
			i2cbb_pkg::CMD_TICK: begin
				unique case (phase_q)
					PH_START: begin
						drv_n = 1'b1;
						phase_n = PH_DELAY;
						dly_n = cfg.step_delay;
						ret_n = PH_START;
						if (sub_q == 2'd0) begin
							sda_n = 1'b1; scl_n = 1'b1; sub_n = 2'd1;
						end else if (sub_q == 2'd1) begin
							sda_n = 1'b0; sub_n = 2'd2;
						end else begin
							scl_n = 1'b0; sub_n = 2'd0; ret_n = PH_TX;
						end
					end
					PH_TX: begin
						drv_n = 1'b1;
						phase_n = PH_DELAY;
						dly_n = cfg.step_delay;
						ret_n = PH_TX;
						if (sub_q == 2'd0) begin
							if (bitc_q >= 4'd8) begin
								bitc_n = 4'd0;
								txsh_n = tx_byte;
								txc_n = txc_inc;
								ret_n = PH_GET_ACK;
							end else begin
								sda_n = txsh_q[7];
								txsh_n = {txsh_q[6:0], 1'b0};
								bitc_n = bitc_inc;
								sub_n = 2'd1;
								scl_n = 1'b1;
							end
						end else if (scl_q) begin
							scl_n = 1'b0; sub_n = 2'd0;
						end
					end
					PH_GET_ACK: begin
						drv_n = 1'b0;
						phase_n = PH_DELAY;
						if (sub_q == 2'd0) begin
							scl_n = 1'b1; sub_n = 2'd1;
							dly_n = cfg.step_delay;
							ret_n = PH_GET_ACK;
						end else begin
							scl_n = 1'b0;
							sub_n = 2'd0;
							dly_n = cfg.ack_delay;
							if (!item.sda_in) begin
								drv_n = 1'b1;
								if (rxm_q) ret_n = PH_RX;
								else if (txc_q > 6'(alen_q)) ret_n = rep_q ? PH_RESTART : PH_STOP;
								else ret_n = PH_TX;
							end else begin
								ret_n = PH_STOP;
								fail_n = 1'b1;
							end
						end
					end
					PH_RX: begin
						drv_n = 1'b0;
						if (sub_q == 2'd0) begin
							scl_n = 1'b1; sub_n = 2'd1;
							phase_n = PH_DELAY;
							dly_n = cfg.step_delay;
							ret_n = PH_RX;
						end else begin
							scl_n = 1'b0;
							rxsh_n = rxsh_shift;
							bitc_n = bitc_inc;
							sub_n = 2'd0;
							if (bitc_inc >= 4'd8) begin
								res.rx_valid = 1'b1;
								res.rx_index = rxc_q[3:0];
								res.rx_byte = rxsh_shift;
								rxc_n = rxc_inc;
								bitc_n = 4'd0;
								phase_n = PH_DELAY;
								dly_n = cfg.step_delay;
								ret_n = (rxc_inc >= alen_q) ? PH_SET_NACK : PH_SET_ACK;
							end
						end
					end
					PH_SET_ACK: begin
						drv_n = 1'b1;
						phase_n = PH_DELAY;
						dly_n = cfg.step_delay;
						if (sub_q == 2'd0) begin
							sda_n = 1'b0; scl_n = 1'b1; sub_n = 2'd1;
							ret_n = PH_SET_ACK;
						end else begin
							scl_n = 1'b0; sda_n = 1'b1; sub_n = 2'd0;
							ret_n = PH_RX;
						end
					end
					PH_SET_NACK: begin
						drv_n = 1'b1;
						phase_n = PH_DELAY;
						dly_n = cfg.step_delay;
						if (sub_q == 2'd0) begin
							sda_n = 1'b1; scl_n = 1'b1; sub_n = 2'd1;
							ret_n = PH_SET_NACK;
						end else begin
							scl_n = 1'b0; sda_n = 1'b0; sub_n = 2'd0;
							ret_n = PH_STOP;
						end
					end
					PH_STOP: begin
						drv_n = 1'b1;
						if (sub_q == 2'd0) begin
							sda_n = 1'b0; scl_n = 1'b0; sub_n = 2'd1;
							phase_n = PH_DELAY; dly_n = cfg.step_delay; ret_n = PH_STOP;
						end else if (sub_q == 2'd1) begin
							scl_n = 1'b1; sub_n = 2'd2;
							phase_n = PH_DELAY; dly_n = cfg.step_delay; ret_n = PH_STOP;
						end else begin
							sda_n = 1'b1;
							res.done_res = 1'b1;
							if (fail_q) res.status = i2cbb_pkg::STAT_NACK;
							else res.status = rxm_q ? i2cbb_pkg::STAT_RD_OK
							                        : i2cbb_pkg::STAT_WR_OK;
							// Clear the transfer
							phase_n = PH_IDLE; sub_n = 2'd0; ret_n = PH_IDLE; dly_n = 8'd0;
							rxsh_n = 8'd0; bitc_n = 4'd0; txc_n = 6'd0; rxc_n = 5'd0;
							alen_n = 5'd0; plen_n = 5'd0;
							rxm_n = 1'b0; rep_n = 1'b0; fail_n = 1'b0;
						end
					end
					PH_RESTART: begin
						alen_n = plen_q; plen_n = 5'd0;
						rxm_n = 1'b1; rep_n = 1'b0; fail_n = 1'b0;
						txsh_n = addr_q | 8'h01;
						rxc_n = 5'd0; txc_n = 6'd0; bitc_n = 4'd0; sub_n = 2'd0;
						phase_n = PH_START;
					end
					PH_DELAY: begin
						dly_n = dly_q - 8'd1;
						if (dly_n == 8'd0) phase_n = ret_q;
					end
					default: begin
					end
				endcase
			end
			i2cbb_pkg::CMD_START: begin
				if (phase_q == PH_IDLE && item.mode != i2cbb_pkg::MODE_INVALID) begin
					sub_n = 2'd0; ret_n = PH_IDLE; dly_n = 8'd0; rxsh_n = 8'd0;
					bitc_n = 4'd0; txc_n = 6'd0; rxc_n = 5'd0;
					plen_n = 5'd0; rxm_n = 1'b0; rep_n = 1'b0; fail_n = 1'b0;
					addr_n = item.bus_addr;
					phase_n = PH_START;
					unique case (item.mode)
						i2cbb_pkg::MODE_READ: begin
							alen_n = item.read_len;
							rxm_n = 1'b1;
							txsh_n = item.bus_addr | 8'h01;
						end
						i2cbb_pkg::MODE_WR_RD: begin
							alen_n = item.write_len;
							plen_n = item.read_len;
							rep_n = 1'b1;
							txsh_n = item.bus_addr & 8'hFE;
						end
						default: begin
							alen_n = item.write_len;
							txsh_n = item.bus_addr & 8'hFE;
						end
					endcase
				end
			end
			default: begin
				// Load items touch only the buffer; code 3 is dropped
			end
		endcase

		res.scl = scl_n;
		res.sda_out = sda_n;
		res.sda_drive = drv_n;
		res.busy_res = (phase_n != PH_IDLE);
	end

	// Hold sequencer state and the line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; ret_q <= PH_IDLE; sub_q <= 2'd0; dly_q <= 8'd0;
			txsh_q <= 8'd0; rxsh_q <= 8'd0; bitc_q <= 4'd0; txc_q <= 6'd0;
			rxc_q <= 5'd0; alen_q <= 5'd0; plen_q <= 5'd0;
			rxm_q <= 1'b0; rep_q <= 1'b0; fail_q <= 1'b0; addr_q <= 8'd0;
			scl_q <= 1'b1; sda_q <= 1'b1; drv_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n; ret_q <= ret_n; sub_q <= sub_n; dly_q <= dly_n;
			txsh_q <= txsh_n; rxsh_q <= rxsh_n; bitc_q <= bitc_n; txc_q <= txc_n;
			rxc_q <= rxc_n; alen_q <= alen_n; plen_q <= plen_n;
			rxm_q <= rxm_n; rep_q <= rep_n; fail_q <= fail_n; addr_q <= addr_n;
			scl_q <= scl_n; sda_q <= sda_n; drv_q <= drv_n;
		end
	end

endmodule

@@ src/i2c_bitbang_master.sv @@
// An accepted item waits in the input register; its result is registered when the result
// slot is empty or being taken. Throughput: one item per cycle while results are taken;
// each tick item moves the sequencer one step. A waiting result stalls a full input register.
// Reset: asynchronous, active low; bus idle with SCL and SDA high, SDA released,
// delay registers at their defaults. The transmit buffer is not cleared.
module i2c_bitbang_master #(
	parameter int BUF_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	i2cbb_in_if.sink          in_ch,
	i2cbb_out_if.source       out_ch,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_wdata
);

	logic                 valid_s1;
	i2cbb_pkg::in_item_t  item_s1;
	logic                 out_valid_q;
	i2cbb_pkg::out_item_t out_data_q;
	i2cbb_pkg::out_item_t res;
	i2cbb_pkg::cfg_t      cfg_q;
	logic                 advance;
	logic                 fire;

	// Advance when the result slot is empty or being taken
	assign advance      = !out_valid_q || out_ch.ready;
	assign fire         = valid_s1 && advance;
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_delay <= i2cbb_pkg::STEP_DELAY_RST;
			cfg_q.ack_delay  <= i2cbb_pkg::ACK_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbb_pkg::REG_STEP_DELAY: cfg_q.step_delay <= cfg_wdata;
				i2cbb_pkg::REG_ACK_DELAY:  cfg_q.ack_delay  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	i2cbb_core #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

endmodule

@@ src/i2cbb_checker.sv @@
// Port-level checker for the I2C bit-bang master and its bind.
`include "assert_macros.svh"

module i2cbb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input i2cbb_pkg::out_item_t out_data
);

	// A stalled result item stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result item keeps its payload
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// Receive fields are zero unless a byte is presented
	`ASSERT_IMPLIES(a_rx_zero, clk, arst_n, out_valid && !out_data.rx_valid, out_data.rx_index == 4'd0 && out_data.rx_byte == 8'd0)

	// Completion leaves the master idle, and status is zero otherwise
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, out_valid && out_data.done_res, !out_data.busy_res)
	`ASSERT_IMPLIES(a_status_zero, clk, arst_n, out_valid && !out_data.done_res, out_data.status == i2cbb_pkg::STAT_WR_OK)

endmodule

bind i2c_bitbang_master i2cbb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

@@ test/i2c_bitbang_master_tb.sv @@
// Self-checking testbench for the I2C bit-bang master: ticks, loads and starts against a predictor.
`timescale 1ns / 1ps

module i2c_bitbang_master_tb;

	localparam int BUF_DEPTH = 16;
	localparam int CYCLE_LIMIT = 100_000;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef enum logic [3:0] {
		BP_IDLE, BP_START, BP_TX, BP_ACK_IN, BP_RX,
		BP_ACK_OUT, BP_NACK_OUT, BP_STOP, BP_RESTART, BP_WAIT
	} bus_phase_t;

	typedef struct packed {
		bus_phase_t       phase;
		bus_phase_t       back;
		logic [1:0]       sub;
		logic [7:0]       wait_left;
		logic [7:0]       tx_sh;
		logic [7:0]       rx_sh;
		logic [3:0]       bits;
		logic [5:0]       tx_cnt;
		logic [4:0]       rx_cnt;
		logic [4:0]       len;
		logic [4:0]       rd_len;
		logic             rx_mode;
		logic             rd_pending;
		logic             failed;
		logic [7:0]       addr;
		logic             scl;
		logic             sda;
		logic             drive;
		logic [7:0]       step_dly;
		logic [7:0]       ack_dly;
		logic [15:0][7:0] buffer;
	} master_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = i2cbb_pkg::REG_STEP_DELAY;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	i2cbb_pkg::in_item_t in_data = '0;
	logic out_ready = 1'b0;
	logic in_fire = 1'b0;

	i2cbb_in_if in_ch();
	i2cbb_out_if out_ch();

	assign in_ch.valid = in_valid;
	assign in_ch.data = in_data;
	assign out_ch.ready = out_ready;

	i2c_bitbang_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// predicted: follows accepted items; lookahead: follows generated items
	master_t predicted;
	master_t lookahead;
	i2cbb_pkg::in_item_t bus_items[$];
	i2cbb_pkg::out_item_t expected_lines[$];
	int sent_cnt = 0;
	int taken_cnt = 0;
	int err_cnt = 0;
	int cycles = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	function automatic master_t fresh_master();
		master_t m;
		m = '0;
		m.phase = BP_IDLE;
		m.back = BP_IDLE;
		m.scl = 1'b1;
		m.sda = 1'b1;
		m.step_dly = i2cbb_pkg::STEP_DELAY_RST;
		m.ack_dly = i2cbb_pkg::ACK_DELAY_RST;
		return m;
	endfunction

	function automatic void park(inout master_t m, input bus_phase_t nxt, input logic [7:0] ticks);
		m.back = nxt;
		m.wait_left = ticks;
		m.phase = BP_WAIT;
	endfunction

	function automatic void clear_xfer(inout master_t m);
		m.phase = BP_IDLE;
		m.back = BP_IDLE;
		m.sub = '0;
		m.wait_left = '0;
		m.rx_sh = '0;
		m.bits = '0;
		m.tx_cnt = '0;
		m.rx_cnt = '0;
		m.len = '0;
		m.rd_len = '0;
		m.rx_mode = 1'b0;
		m.rd_pending = 1'b0;
		m.failed = 1'b0;
	endfunction

	// Advance the master by one item and return the bus lines after it
	function automatic i2cbb_pkg::out_item_t master_step(inout master_t m,
			input i2cbb_pkg::in_item_t it);
		i2cbb_pkg::out_item_t r;
		bus_phase_t nxt;
		r = '0;
		case (it.cmd)
		i2cbb_pkg::CMD_TICK: begin
			case (m.phase)
			BP_START: begin
				m.drive = 1'b1;
				if (m.sub == 2'd0) begin
					m.sda = 1'b1;
					m.scl = 1'b1;
					m.sub = 2'd1;
					park(m, BP_START, m.step_dly);
				end else if (m.sub == 2'd1) begin
					m.sda = 1'b0;
					m.sub = 2'd2;
					park(m, BP_START, m.step_dly);
				end else begin
					m.scl = 1'b0;
					m.sub = 2'd0;
					park(m, BP_TX, m.step_dly);
				end
			end
			BP_TX: begin
				m.drive = 1'b1;
				if (m.sub == 2'd0) begin
					if (m.bits >= 4'd8) begin
						// fetch the next data byte; past the buffer it reads as zero
						m.bits = '0;
						m.tx_sh = (m.tx_cnt < BUF_DEPTH) ? m.buffer[m.tx_cnt[3:0]] : 8'h00;
						m.tx_cnt = m.tx_cnt + 6'd1;
						park(m, BP_ACK_IN, m.step_dly);
					end else begin
						m.sda = m.tx_sh[7];
						m.tx_sh = {m.tx_sh[6:0], 1'b0};
						m.bits = m.bits + 4'd1;
						m.sub = 2'd1;
						m.scl = 1'b1;
						park(m, BP_TX, m.step_dly);
					end
				end else begin
					if (m.scl) begin
						m.scl = 1'b0;
						m.sub = 2'd0;
					end
					park(m, BP_TX, m.step_dly);
				end
			end
			BP_ACK_IN: begin
				m.drive = 1'b0;
				if (m.sub == 2'd0) begin
					m.scl = 1'b1;
					m.sub = 2'd1;
					park(m, BP_ACK_IN, m.step_dly);
				end else begin
					m.scl = 1'b0;
					if (!it.sda_in) begin
						if (m.rx_mode)
							nxt = BP_RX;
						else if (m.tx_cnt > {1'b0, m.len})
							nxt = m.rd_pending ? BP_RESTART : BP_STOP;
						else
							nxt = BP_TX;
						m.drive = 1'b1;
					end else begin
						nxt = BP_STOP;
						m.failed = 1'b1;
					end
					m.sub = 2'd0;
					park(m, nxt, m.ack_dly);
				end
			end
			BP_RX: begin
				m.drive = 1'b0;
				if (m.sub == 2'd0) begin
					m.scl = 1'b1;
					m.sub = 2'd1;
					park(m, BP_RX, m.step_dly);
				end else begin
					m.scl = 1'b0;
					m.rx_sh = {m.rx_sh[6:0], it.sda_in};
					m.bits = m.bits + 4'd1;
					m.sub = 2'd0;
					if (m.bits >= 4'd8) begin
						r.rx_valid = 1'b1;
						r.rx_index = m.rx_cnt[3:0];
						r.rx_byte = m.rx_sh;
						m.rx_cnt = m.rx_cnt + 5'd1;
						m.bits = '0;
						park(m, (m.rx_cnt >= m.len) ? BP_NACK_OUT : BP_ACK_OUT, m.step_dly);
					end
				end
			end
			BP_ACK_OUT: begin
				m.drive = 1'b1;
				if (m.sub == 2'd0) begin
					m.sda = 1'b0;
					m.scl = 1'b1;
					m.sub = 2'd1;
					park(m, BP_ACK_OUT, m.step_dly);
				end else begin
					m.scl = 1'b0;
					m.sda = 1'b1;
					m.sub = 2'd0;
					park(m, BP_RX, m.step_dly);
				end
			end
			BP_NACK_OUT: begin
				m.drive = 1'b1;
				if (m.sub == 2'd0) begin
					m.sda = 1'b1;
					m.scl = 1'b1;
					m.sub = 2'd1;
					park(m, BP_NACK_OUT, m.step_dly);
				end else begin
					m.scl = 1'b0;
					m.sda = 1'b0;
					m.sub = 2'd0;
					park(m, BP_STOP, m.step_dly);
				end
			end
			BP_STOP: begin
				m.drive = 1'b1;
				if (m.sub == 2'd0) begin
					m.sda = 1'b0;
					m.scl = 1'b0;
					m.sub = 2'd1;
					park(m, BP_STOP, m.step_dly);
				end else if (m.sub == 2'd1) begin
					m.scl = 1'b1;
					m.sub = 2'd2;
					park(m, BP_STOP, m.step_dly);
				end else begin
					m.sda = 1'b1;
					r.done_res = 1'b1;
					if (m.failed)
						r.status = i2cbb_pkg::STAT_NACK;
					else
						r.status = m.rx_mode ? i2cbb_pkg::STAT_RD_OK : i2cbb_pkg::STAT_WR_OK;
					clear_xfer(m);
				end
			end
			BP_RESTART: begin
				// swap in the pending read and resend the address with the read bit
				m.len = m.rd_len;
				m.rd_len = '0;
				m.rx_mode = 1'b1;
				m.rd_pending = 1'b0;
				m.failed = 1'b0;
				m.tx_sh = m.addr | 8'h01;
				m.rx_cnt = '0;
				m.tx_cnt = '0;
				m.bits = '0;
				m.sub = 2'd0;
				m.phase = BP_START;
			end
			BP_WAIT: begin
				m.wait_left = m.wait_left - 8'd1;
				if (m.wait_left == 8'd0)
					m.phase = m.back;
			end
			default: ;
			endcase
		end
		i2cbb_pkg::CMD_LOAD: begin
			m.buffer[it.load_index] = it.load_data;
		end
		i2cbb_pkg::CMD_START: begin
			if (m.phase == BP_IDLE && it.mode != i2cbb_pkg::MODE_INVALID) begin
				clear_xfer(m);
				m.addr = it.bus_addr;
				case (it.mode)
				i2cbb_pkg::MODE_WRITE: begin
					m.len = it.write_len;
					m.tx_sh = it.bus_addr & 8'hFE;
				end
				i2cbb_pkg::MODE_READ: begin
					m.len = it.read_len;
					m.rx_mode = 1'b1;
					m.tx_sh = it.bus_addr | 8'h01;
				end
				default: begin
					m.len = it.write_len;
					m.rd_len = it.read_len;
					m.rd_pending = 1'b1;
					m.tx_sh = it.bus_addr & 8'hFE;
				end
				endcase
				m.phase = BP_START;
			end
		end
		default: ;
		endcase
		r.scl = m.scl;
		r.sda_out = m.sda;
		r.sda_drive = m.drive;
		r.busy_res = (m.phase != BP_IDLE);
		return r;
	endfunction

	function automatic i2cbb_pkg::in_item_t random_item();
		i2cbb_pkg::in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.sda_in = 1'($urandom);
		it.bus_addr = 8'($urandom);
		it.write_len = 5'($urandom);
		it.read_len = 5'($urandom);
		it.mode = 2'($urandom);
		it.load_index = 4'($urandom);
		it.load_data = 8'($urandom);
		return it;
	endfunction

	// Mostly empty or single-byte transfers, now and then two bytes
	function automatic logic [4:0] pick_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 5'd0;
		else if (roll < 85)
			return 5'd1;
		return 5'd2;
	endfunction

	// Queue an item and track where the bus will be once it is taken
	function automatic void send_item(input i2cbb_pkg::in_item_t it);
		void'(master_step(lookahead, it));
		bus_items.push_back(it);
		sent_cnt++;
	endfunction

	// Start a transfer and tick it to the stop, playing the slave on SDA
	task automatic run_xfer(input logic [1:0] mode, input logic [7:0] addr,
			input logic [4:0] wlen, input logic [4:0] rlen, input int nack_pct,
			input bit twice);
		i2cbb_pkg::in_item_t it;
		it = random_item();
		it.cmd = i2cbb_pkg::CMD_START;
		it.mode = mode;
		it.bus_addr = addr;
		it.write_len = wlen;
		it.read_len = rlen;
		send_item(it);
		if (twice) begin
			it = random_item();
			it.cmd = i2cbb_pkg::CMD_START;
			send_item(it);
		end
		while (lookahead.phase != BP_IDLE) begin
			it = random_item();
			if ($urandom_range(0, 99) < 4) begin
				case ($urandom_range(0, 2))
				0: it.cmd = i2cbb_pkg::CMD_LOAD;
				1: it.cmd = i2cbb_pkg::CMD_START;
				default: it.cmd = CMD_NONE;
				endcase
			end else begin
				it.cmd = i2cbb_pkg::CMD_TICK;
				if (lookahead.phase == BP_ACK_IN && lookahead.sub == 2'd1)
					it.sda_in = ($urandom_range(0, 99) < nack_pct);
			end
			send_item(it);
		end
	endtask

	task automatic wait_drain();
		while (taken_cnt != sent_cnt || expected_lines.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == i2cbb_pkg::REG_STEP_DELAY) begin
			predicted.step_dly = val;
			lookahead.step_dly = val;
		end else begin
			predicted.ack_dly = val;
			lookahead.ack_dly = val;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic enter_phase(input int gap, input int stall, input logic [7:0] step,
			input logic [7:0] ack);
		wait_drain();
		write_reg(i2cbb_pkg::REG_STEP_DELAY, step);
		write_reg(i2cbb_pkg::REG_ACK_DELAY, ack);
		send_gap_pct = gap;
		recv_stall_pct = stall;
	endtask

	// Run random transfers with bits of idle noise between them
	task automatic random_traffic(input int quota);
		i2cbb_pkg::in_item_t it;
		int start;
		start = sent_cnt;
		while (sent_cnt - start < quota) begin
			repeat ($urandom_range(0, 2)) begin
				it = random_item();
				if (it.cmd == i2cbb_pkg::CMD_START)
					it.mode = i2cbb_pkg::MODE_INVALID;
				send_item(it);
			end
			run_xfer(2'($urandom_range(0, 2)), 8'($urandom), pick_len(), pick_len(),
				($urandom_range(0, 99) < 25) ? 50 : 0, $urandom_range(0, 9) == 0);
		end
	endtask

	// Offer the next item once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (bus_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				in_data <= bus_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n ? ($urandom_range(0, 99) >= recv_stall_pct) : 1'b0;
	end

	// Predict on each accepted item, check each accepted result
	always @(posedge clk) begin : scoreboard
		i2cbb_pkg::out_item_t got;
		i2cbb_pkg::out_item_t want;
		in_fire <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_lines.push_back(master_step(predicted, in_ch.data));
			taken_cnt++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_lines.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("cycle %0d: result with nothing expected: %h", cycles, got);
			end else begin
				want = expected_lines.pop_front();
				if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
						got.sda_drive !== want.sda_drive || got.rx_valid !== want.rx_valid ||
						got.rx_index !== want.rx_index || got.rx_byte !== want.rx_byte ||
						got.done_res !== want.done_res || got.status !== want.status ||
						got.busy_res !== want.busy_res) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"cycle %0d mismatch (expected/actual): scl %b/%b ",
							"sda_out %b/%b sda_drive %b/%b rx_valid %b/%b rx_index %0d/%0d ",
							"rx_byte %h/%h done %b/%b status %0d/%0d busy %b/%b"},
							cycles, want.scl, got.scl, want.sda_out, got.sda_out,
							want.sda_drive, got.sda_drive, want.rx_valid, got.rx_valid,
							want.rx_index, got.rx_index, want.rx_byte, got.rx_byte,
							want.done_res, got.done_res, want.status, got.status,
							want.busy_res, got.busy_res);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		i2cbb_pkg::in_item_t it;
		predicted = fresh_master();
		lookahead = fresh_master();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: fill the buffer, odd commands, then one transfer per corner
		enter_phase(0, 0, i2cbb_pkg::STEP_DELAY_RST, 8'd1);
		for (int i = 0; i < BUF_DEPTH; i++) begin
			it = random_item();
			it.cmd = i2cbb_pkg::CMD_LOAD;
			it.load_index = 4'(i);
			it.load_data = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
			send_item(it);
		end
		it = random_item();
		it.cmd = CMD_NONE;
		send_item(it);
		it = random_item();
		it.cmd = i2cbb_pkg::CMD_START;
		it.mode = i2cbb_pkg::MODE_INVALID;
		send_item(it);
		it = random_item();
		it.cmd = i2cbb_pkg::CMD_TICK;
		send_item(it);
		run_xfer(i2cbb_pkg::MODE_WRITE, 8'hFF, 5'd1, 5'd0, 0, 1'b1);
		run_xfer(i2cbb_pkg::MODE_WR_RD, 8'hA5, 5'd1, 5'd1, 0, 1'b0);
		run_xfer(i2cbb_pkg::MODE_WRITE, 8'h5A, 5'd2, 5'd0, 100, 1'b0);

		// Random transfers under each idling pattern
		enter_phase(0, 0, 8'd1, 8'd1);
		random_traffic(40);
		enter_phase(55, 0, 8'd1, 8'($urandom_range(1, 4)));
		random_traffic(40);
		enter_phase(0, 55, 8'd1, 8'($urandom_range(1, 4)));
		random_traffic(40);
		enter_phase(31, 31, 8'd1, 8'($urandom_range(1, 4)));
		random_traffic(40);

		// Zero acknowledge delay wraps to the longest wait; read length zero
		enter_phase(0, 0, 8'd1, 8'd0);
		run_xfer(i2cbb_pkg::MODE_READ, 8'($urandom), 5'd0, 5'd0, 0, 1'b0);

		wait_drain();
		repeat (4) @(negedge clk);
		if (err_cnt == 0 && expected_lines.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ i2c_bitbang_master.f @@
+incdir+src
src/i2cbb_pkg.sv
src/i2cbb_if.sv
src/i2cbb_core.sv
src/i2c_bitbang_master.sv
src/i2cbb_checker.sv
test/i2c_bitbang_master_tb.sv
